### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the unsigned integer text parser.
// Depends on nothing; the assertions are left out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/uitp_pkg.sv
// Package of the unsigned integer text parser: widths, character codes,
// base codes, the parse phase type and the step control struct. No dependencies.
package uitp_pkg;

   localparam int CHAR_WIDTH           = 8;
   localparam int VALUE_WIDTH          = 64;
   localparam int BASE_WIDTH           = 6;
   localparam int DIGIT_WIDTH          = 4;
   localparam int OFFSET_OUT_WIDTH     = 16;
   localparam int OFFSET_WIDTH_DEFAULT = 16;

   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;

   localparam logic [BASE_WIDTH-1:0] RADIX_AUTO = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;

   typedef enum logic [1:0] {
      PH_DONE   = 2'd0,
      PH_LEAD   = 2'd1,
      PH_ZERO   = 2'd2,
      PH_DIGITS = 2'd3
   } uitp_phase_type;

   typedef struct packed {
      uitp_phase_type phase_next;
      logic           emit;
   } uitp_ctl_type;

endpackage

### rtl/uitp_req_if.sv
// Character channel of the unsigned integer text parser: valid, ready and
// one character with its start flag. Depends on uitp_pkg.
interface uitp_req_if;
   import uitp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_in;
   logic                  start_req;

   modport source (output valid, output char_in, output start_req, input ready);
   modport sink (input valid, input char_in, input start_req, output ready);
endinterface

### rtl/uitp_rsp_if.sv
// Result channel of the unsigned integer text parser: valid, ready, the
// parsed value, the stop offset and the base used. Depends on uitp_pkg.
interface uitp_rsp_if;
   import uitp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [VALUE_WIDTH-1:0]      value;
   logic [OFFSET_OUT_WIDTH-1:0] end_offset;
   logic [BASE_WIDTH-1:0]       base_used;

   modport source (output valid, output value, output end_offset, output base_used,
                   input ready);
   modport sink (input valid, input value, input end_offset, input base_used,
                 output ready);
endinterface

### rtl/uitp_step.sv
// Combinational parse step: applies one character to the parse state and
// decides whether the parse ends here. Depends on uitp_pkg.
module uitp_step #(
   parameter int OFFSET_WIDTH = uitp_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic [uitp_pkg::CHAR_WIDTH-1:0]  char_in,
   input  logic                             start_req,
   input  logic [uitp_pkg::BASE_WIDTH-1:0]  radix,
   input  uitp_pkg::uitp_phase_type         phase,
   input  logic [uitp_pkg::VALUE_WIDTH-1:0] acc,
   input  logic [uitp_pkg::BASE_WIDTH-1:0]  base,
   input  logic [OFFSET_WIDTH-1:0]          pos,
   output uitp_pkg::uitp_ctl_type           ctl,
   output logic [uitp_pkg::VALUE_WIDTH-1:0] acc_next,
   output logic [uitp_pkg::BASE_WIDTH-1:0]  base_next,
   output logic [OFFSET_WIDTH-1:0]          pos_next,
   output logic [uitp_pkg::VALUE_WIDTH-1:0] res_value,
   output logic [OFFSET_WIDTH-1:0]          res_pos,
   output logic [uitp_pkg::BASE_WIDTH-1:0]  res_base
);
   import uitp_pkg::*;

   uitp_phase_type         ph_s;
   logic [VALUE_WIDTH-1:0] acc_s;
   logic [BASE_WIDTH-1:0]  base_s;
   logic [OFFSET_WIDTH-1:0] pos_s;
   logic [OFFSET_WIDTH:0]  sum1;
   logic [OFFSET_WIDTH:0]  sum2;
   logic [OFFSET_WIDTH-1:0] adv1;
   logic [OFFSET_WIDTH-1:0] adv2;
   logic                   is_digit;
   logic [DIGIT_WIDTH-1:0] digit;
   logic                   blank;
   logic                   detect;
   logic [BASE_WIDTH-1:0]  base_t;
   logic [VALUE_WIDTH-1:0] acc_t;
   logic [OFFSET_WIDTH-1:0] pos_t;
   logic [OFFSET_WIDTH-1:0] pos_take;
   logic                   take;
   logic [VALUE_WIDTH-1:0] acc_sum;

   // A start discards whatever parse was in progress.
   always_comb begin
      ph_s   = start_req ? PH_LEAD : phase;
      acc_s  = start_req ? '0 : acc;
      base_s = start_req ? '0 : base;
      pos_s  = start_req ? '0 : pos;
   end

   // Offsets saturate at all ones; the extra sum bit flags the overflow.
   always_comb begin
      sum1 = {1'b0, pos_s} + (OFFSET_WIDTH+1)'(1);
      sum2 = {1'b0, pos_s} + (OFFSET_WIDTH+1)'(2);
      adv1 = sum1[OFFSET_WIDTH] ? '1 : sum1[OFFSET_WIDTH-1:0];
      adv2 = sum2[OFFSET_WIDTH] ? '1 : sum2[OFFSET_WIDTH-1:0];
   end

   always_comb begin
      is_digit = 1'b1;
      digit    = '0;
      if (char_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
         digit = DIGIT_WIDTH'(char_in - CHAR_ZERO);
      end else if (char_in inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         digit = DIGIT_WIDTH'(char_in - CHAR_LOWER_A + 8'd10);
      end else if (char_in inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         digit = DIGIT_WIDTH'(char_in - CHAR_UPPER_A + 8'd10);
      end else begin
         is_digit = 1'b0;
      end
   end

   always_comb begin
      blank  = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB);
      detect = (radix == RADIX_AUTO) || (radix == BASE_HEX);
      if (ph_s == PH_LEAD) begin
         base_t = (radix == RADIX_AUTO) ? BASE_DEC : radix;
      end else begin
         base_t = base_s;
      end
      // After a lone leading zero, that zero counts as one digit of value zero.
      acc_t    = (ph_s == PH_ZERO) ? '0 : acc_s;
      pos_t    = (ph_s == PH_ZERO) ? adv1 : pos_s;
      pos_take = (ph_s == PH_ZERO) ? adv2 : adv1;
      take     = is_digit && ({2'b00, digit} < base_t);
      acc_sum  = VALUE_WIDTH'(acc_t * VALUE_WIDTH'(base_t)) + VALUE_WIDTH'(digit);
   end

   always_comb begin
      ctl.phase_next = ph_s;
      ctl.emit       = 1'b0;
      acc_next       = acc_s;
      base_next      = base_s;
      pos_next       = pos_s;
      case (ph_s)
         PH_LEAD: begin
            if (blank) begin
               pos_next = adv1;
            end else if (detect && (char_in == CHAR_ZERO)) begin
               base_next      = (radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
               ctl.phase_next = PH_ZERO;
            end else if (take) begin
               base_next      = base_t;
               acc_next       = acc_sum;
               pos_next       = pos_take;
               ctl.phase_next = PH_DIGITS;
            end else begin
               base_next      = base_t;
               ctl.emit       = 1'b1;
               ctl.phase_next = PH_DONE;
            end
         end
         PH_ZERO: begin
            if ((char_in == CHAR_LOWER_X) || (char_in == CHAR_UPPER_X)) begin
               base_next      = BASE_HEX;
               pos_next       = adv2;
               ctl.phase_next = PH_DIGITS;
            end else if (take) begin
               acc_next       = acc_sum;
               pos_next       = pos_take;
               ctl.phase_next = PH_DIGITS;
            end else begin
               ctl.emit       = 1'b1;
               ctl.phase_next = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (take) begin
               acc_next = acc_sum;
               pos_next = pos_take;
            end else begin
               ctl.emit       = 1'b1;
               ctl.phase_next = PH_DONE;
            end
         end
         default: begin
            ctl.phase_next = PH_DONE;
         end
      endcase
   end

   assign res_value = acc_t;
   assign res_pos   = pos_t;
   assign res_base  = base_t;

endmodule

### rtl/unsigned_integer_text_parser.sv
// Unsigned integer text parser, strtoull style with 64-bit wraparound.
// Characters arrive on req_chan, one per transfer; start_req marks the first
// character of a string. Leading blanks are skipped, a 0x/0X prefix or a
// leading zero picks the base when csr radix allows it, and digits are
// accumulated until a NUL, a non-digit or a digit too large for the base.
// That stopping character yields one transfer on rsp_chan with the value,
// its offset (saturating) and the base used; other characters yield none.
// A character is taken into an input register, then applied to the parse
// state by one multiply-add step that loads the result register, from which
// the result can transfer. The character waits in the input register while
// the result register is busy. The block takes one character per cycle while
// rsp_chan is not stalled.
// While a result waits for rsp_chan.ready, the character in the input
// register is held and req_chan.ready drops once that register is full.
// csr_we writes the radix; it is sampled at the first non-blank character.
// Reset clears the radix to 0 (auto-detect), empties both registers and
// leaves the parser waiting for a start.
module unsigned_integer_text_parser #(
   parameter int OFFSET_WIDTH = uitp_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   uitp_req_if.sink                        req_chan,
   uitp_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [uitp_pkg::BASE_WIDTH-1:0] csr_wdata
);
   import uitp_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0]   in_char_ff, in_char_in;
   logic                    in_start_ff, in_start_in;
   logic [BASE_WIDTH-1:0]   radix_ff, radix_in;
   uitp_phase_type          phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic [BASE_WIDTH-1:0]   base_ff, base_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic [OFFSET_OUT_WIDTH-1:0] rsp_off_ff, rsp_off_in;
   logic [BASE_WIDTH-1:0]   rsp_base_ff, rsp_base_in;

   uitp_ctl_type            step_ctl;
   logic [VALUE_WIDTH-1:0]  step_acc;
   logic [BASE_WIDTH-1:0]   step_base;
   logic [OFFSET_WIDTH-1:0] step_pos;
   logic [VALUE_WIDTH-1:0]  res_value;
   logic [OFFSET_WIDTH-1:0] res_pos;
   logic [BASE_WIDTH-1:0]   res_base;
   logic [OFFSET_WIDTH+OFFSET_OUT_WIDTH-1:0] res_pos_ext;
   logic                    advance;

   uitp_step #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_step (
      .char_in   (in_char_ff),
      .start_req (in_start_ff),
      .radix     (radix_ff),
      .phase     (phase_ff),
      .acc       (acc_ff),
      .base      (base_ff),
      .pos       (pos_ff),
      .ctl       (step_ctl),
      .acc_next  (step_acc),
      .base_next (step_base),
      .pos_next  (step_pos),
      .res_value (res_value),
      .res_pos   (res_pos),
      .res_base  (res_base)
   );

   // The held character is applied once the result register can take a result.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign res_pos_ext    = {{OFFSET_OUT_WIDTH{1'b0}}, res_pos};

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_start_in = in_start_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_chan.char_in;
         in_start_in = req_chan.start_req;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      radix_in = csr_we ? csr_wdata : radix_ff;

      phase_in = phase_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      if (advance) begin
         phase_in = step_ctl.phase_next;
         acc_in   = step_acc;
         base_in  = step_base;
         pos_in   = step_pos;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_base_in  = rsp_base_ff;
      if (advance && step_ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value;
         rsp_off_in   = res_pos_ext[OFFSET_OUT_WIDTH-1:0];
         rsp_base_in  = res_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         radix_ff     <= RADIX_AUTO;
         phase_ff     <= PH_DONE;
         acc_ff       <= '0;
         base_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         radix_ff     <= radix_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         base_ff      <= base_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      in_start_ff  <= in_start_in;
      rsp_value_ff <= rsp_value_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_base_ff  <= rsp_base_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = rsp_value_ff;
   assign rsp_chan.end_offset = rsp_off_ff;
   assign rsp_chan.base_used  = rsp_base_ff;

`include "assert_macros.svh"

   `ASSERT_NEXT(a_emit_loads_rsp, clock, reset, advance && step_ctl.emit, rsp_valid_ff, "result was not registered")
   `ASSERT_NEXT(a_emit_ends_parse, clock, reset, advance && step_ctl.emit, phase_ff == PH_DONE, "parse did not end after its result")
   `ASSERT_NEXT(a_held_char_stays, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_char_ff) && $stable(in_start_ff), "stalled character was lost")
   `ASSERT_IMPL(a_done_is_silent, clock, reset, advance && !in_start_ff && (phase_ff == PH_DONE), !step_ctl.emit, "result without a parse")

endmodule
